// File: rtl/core/rpcrm_pkg.sv
// Shared types and constants for the RPC record-mark deframer and reply matcher.
package rpcrm_pkg;

    localparam int PENDING_SLOTS_DEF = 16;

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_REGISTER = 2'd1;
    localparam logic [1:0] KIND_WITHDRAW = 2'd2;

    localparam logic [30:0] FRAG_LEN_MASK = 31'h7fffffff;

    typedef enum logic [3:0] {
        EV_CONSUMED   = 4'd0,
        EV_MATCHED    = 4'd1,
        EV_UNMATCHED  = 4'd2,
        EV_CALL_ON    = 4'd3,
        EV_CALL_DROP  = 4'd4,
        EV_CORRUPT    = 4'd5,
        EV_REGISTERED = 4'd6,
        EV_FULL       = 4'd7,
        EV_WITHDRAWN  = 4'd8,
        EV_NOT_FOUND  = 4'd9,
        EV_REFUSED    = 4'd10
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FREE,
        ST_READ,
        ST_CMP
    } state_t;

endpackage

// File: rtl/core/rpc_record_mark_reply_matcher_unit.sv
// Stream bytes, calls, corrupt records and refused beats reach the output the next cycle.
// Registration scans the valid bits, one slot per cycle.
// Reply match and withdraw scan the id memory through its registered read port, reading a
// slot in ST_READ and comparing it in ST_CMP; one beat is in flight at a time.
// Reset clears the framing state, all pending valid bits and the broken-link flag at once;
// the id memory is not cleared and is only read behind its valid bit.
module rpc_record_mark_reply_matcher_unit #(
    parameter int PENDING_SLOTS = rpcrm_pkg::PENDING_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic [31:0] request_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  event_res,
    output logic        byte_valid,
    output logic [7:0]  out_byte,
    output logic        record_last,
    output logic [31:0] reply_id,
    output logic [3:0]  slot
);
    import rpcrm_pkg::*;

    localparam int IDX_W = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PENDING_SLOTS - 1);

    state_t state_reg, state_next;

    logic                     backchannel_reg;
    logic [1:0]               mark_cnt_reg, mark_cnt_next;
    logic [23:0]              mark_shift_reg, mark_shift_next;
    logic [30:0]              bytes_left_reg, bytes_left_next;
    logic                     final_frag_reg, final_frag_next;
    logic [3:0]               rec_cnt_reg, rec_cnt_next;
    logic [31:0]              record_id_reg, record_id_next;
    logic                     dir_nz_reg, dir_nz_next;
    logic                     broken_reg, broken_next;
    logic [PENDING_SLOTS-1:0] pvalid_reg, pvalid_next;
    logic [IDX_W-1:0]         scan_idx_reg, scan_idx_next;
    logic [31:0]              key_reg, key_next;
    logic                     is_reply_reg, is_reply_next;

    logic                     out_valid_reg, out_valid_next;
    event_t                   event_reg, event_next;
    logic                     byte_valid_reg, byte_valid_next;
    logic [7:0]               out_byte_reg, out_byte_next;
    logic                     record_last_reg, record_last_next;
    logic [31:0]              reply_id_reg, reply_id_next;
    logic [3:0]               slot_reg, slot_next;

    logic [31:0]              id_mem [PENDING_SLOTS];
    logic [31:0]              rd_data_reg;
    logic                     mem_we;

    logic                     accept;
    logic                     rec_end;
    logic                     rec_short;
    logic                     dir_nz_new;
    logic [31:0]              rec_id_new;
    logic [31:0]              mark_full;
    logic                     free_hit;
    logic                     cmp_hit;
    logic                     scan_last;
    logic [IDX_W+3:0]         slot_ext;

    assign in_stall  = !((state_reg == ST_IDLE) && (!out_valid_reg || !out_stall));
    assign accept    = in_valid && !in_stall;

    assign mark_full  = {mark_shift_reg, data_byte};
    assign rec_end    = (bytes_left_reg == 31'd1) && final_frag_reg;
    assign rec_short  = (rec_cnt_reg < 4'd7);
    assign rec_id_new = (rec_cnt_reg < 4'd4) ? {record_id_reg[23:0], data_byte}
                                             : record_id_reg;
    assign dir_nz_new = dir_nz_reg ||
                        ((rec_cnt_reg >= 4'd4) && (rec_cnt_reg < 4'd8) && (data_byte != 8'd0));

    assign free_hit  = !pvalid_reg[scan_idx_reg];
    assign cmp_hit   = pvalid_reg[scan_idx_reg] && (rd_data_reg == key_reg);
    assign scan_last = (scan_idx_reg == LAST_IDX);
    assign slot_ext  = {4'd0, scan_idx_reg};
    assign mem_we    = (state_reg == ST_FREE) && free_hit;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !broken_reg)
                begin
                    if (kind == KIND_REGISTER)
                    begin
                        state_next = ST_FREE;
                    end
                    else if (kind == KIND_WITHDRAW)
                    begin
                        state_next = ST_READ;
                    end
                    else if ((kind == KIND_BYTE) && (bytes_left_reg != 31'd0) && rec_end &&
                             !rec_short && dir_nz_new)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_FREE:
            begin
                if (free_hit || scan_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (cmp_hit || scan_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result register updates.
    always_comb
    begin
        mark_cnt_next    = mark_cnt_reg;
        mark_shift_next  = mark_shift_reg;
        bytes_left_next  = bytes_left_reg;
        final_frag_next  = final_frag_reg;
        rec_cnt_next     = rec_cnt_reg;
        record_id_next   = record_id_reg;
        dir_nz_next      = dir_nz_reg;
        broken_next      = broken_reg;
        pvalid_next      = pvalid_reg;
        scan_idx_next    = scan_idx_reg;
        key_next         = key_reg;
        is_reply_next    = is_reply_reg;
        out_valid_next   = out_valid_reg && out_stall;
        event_next       = event_reg;
        byte_valid_next  = byte_valid_reg;
        out_byte_next    = out_byte_reg;
        record_last_next = record_last_reg;
        reply_id_next    = reply_id_reg;
        slot_next        = slot_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    event_next       = EV_CONSUMED;
                    byte_valid_next  = 1'b0;
                    out_byte_next    = 8'd0;
                    record_last_next = 1'b0;
                    reply_id_next    = 32'd0;
                    slot_next        = 4'd0;
                    out_valid_next   = 1'b1;
                    scan_idx_next    = '0;
                    if (broken_reg)
                    begin
                        event_next = EV_REFUSED;
                    end
                    else if (kind == KIND_BYTE)
                    begin
                        if (bytes_left_reg == 31'd0)
                        begin
                            if (mark_cnt_reg == 2'd3)
                            begin
                                bytes_left_next = mark_full[30:0] & FRAG_LEN_MASK;
                                final_frag_next = mark_full[31];
                                mark_cnt_next   = 2'd0;
                                mark_shift_next = 24'd0;
                            end
                            else
                            begin
                                mark_cnt_next   = mark_cnt_reg + 2'd1;
                                mark_shift_next = {mark_shift_reg[15:0], data_byte};
                            end
                        end
                        else
                        begin
                            byte_valid_next = 1'b1;
                            out_byte_next   = data_byte;
                            bytes_left_next = bytes_left_reg - 31'd1;
                            record_id_next  = rec_id_new;
                            dir_nz_next     = dir_nz_new;
                            if (rec_cnt_reg < 4'd8)
                            begin
                                rec_cnt_next = rec_cnt_reg + 4'd1;
                            end
                            if (rec_end)
                            begin
                                record_last_next = 1'b1;
                                rec_cnt_next     = 4'd0;
                                record_id_next   = 32'd0;
                                dir_nz_next      = 1'b0;
                                if (rec_short)
                                begin
                                    event_next  = EV_CORRUPT;
                                    broken_next = 1'b1;
                                    pvalid_next = '0;
                                end
                                else
                                begin
                                    reply_id_next = rec_id_new;
                                    if (!dir_nz_new)
                                    begin
                                        event_next = backchannel_reg ? EV_CALL_ON
                                                                     : EV_CALL_DROP;
                                    end
                                    else
                                    begin
                                        key_next       = rec_id_new;
                                        is_reply_next  = 1'b1;
                                        out_valid_next = 1'b0;
                                    end
                                end
                            end
                        end
                    end
                    else if (kind == KIND_REGISTER)
                    begin
                        key_next       = request_id;
                        out_valid_next = 1'b0;
                    end
                    else if (kind == KIND_WITHDRAW)
                    begin
                        key_next       = request_id;
                        is_reply_next  = 1'b0;
                        out_valid_next = 1'b0;
                    end
                end
            end
            ST_FREE:
            begin
                if (free_hit)
                begin
                    pvalid_next[scan_idx_reg] = 1'b1;
                    event_next     = EV_REGISTERED;
                    slot_next      = slot_ext[3:0];
                    out_valid_next = 1'b1;
                end
                else if (scan_last)
                begin
                    event_next     = EV_FULL;
                    out_valid_next = 1'b1;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_READ:
            begin
                scan_idx_next = scan_idx_reg;
            end
            ST_CMP:
            begin
                if (cmp_hit)
                begin
                    pvalid_next[scan_idx_reg] = 1'b0;
                    event_next     = is_reply_reg ? EV_MATCHED : EV_WITHDRAWN;
                    slot_next      = slot_ext[3:0];
                    out_valid_next = 1'b1;
                end
                else if (scan_last)
                begin
                    event_next     = is_reply_reg ? EV_UNMATCHED : EV_NOT_FOUND;
                    out_valid_next = 1'b1;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            backchannel_reg <= 1'b0;
            mark_cnt_reg    <= 2'd0;
            mark_shift_reg  <= 24'd0;
            bytes_left_reg  <= 31'd0;
            final_frag_reg  <= 1'b0;
            rec_cnt_reg     <= 4'd0;
            record_id_reg   <= 32'd0;
            dir_nz_reg      <= 1'b0;
            broken_reg      <= 1'b0;
            pvalid_reg      <= '0;
            scan_idx_reg    <= '0;
            is_reply_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                backchannel_reg <= cfg_data;
            end
            mark_cnt_reg   <= mark_cnt_next;
            mark_shift_reg <= mark_shift_next;
            bytes_left_reg <= bytes_left_next;
            final_frag_reg <= final_frag_next;
            rec_cnt_reg    <= rec_cnt_next;
            record_id_reg  <= record_id_next;
            dir_nz_reg     <= dir_nz_next;
            broken_reg     <= broken_next;
            pvalid_reg     <= pvalid_next;
            scan_idx_reg   <= scan_idx_next;
            is_reply_reg   <= is_reply_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg          <= key_next;
        event_reg        <= event_next;
        byte_valid_reg   <= byte_valid_next;
        out_byte_reg     <= out_byte_next;
        record_last_reg  <= record_last_next;
        reply_id_reg     <= reply_id_next;
        slot_reg         <= slot_next;
    end

    // Pending id store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            id_mem[scan_idx_reg] <= key_reg;
        end
        rd_data_reg <= id_mem[scan_idx_reg];
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = event_reg;
    assign byte_valid  = byte_valid_reg;
    assign out_byte    = out_byte_reg;
    assign record_last = record_last_reg;
    assign reply_id    = reply_id_reg;
    assign slot        = slot_reg;

endmodule

// File: verif/tb.sv
// Testbench for the RPC record-mark deframer and reply matcher against a scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpcrm_pkg::*;

    localparam int SLOTS = PENDING_SLOTS_DEF;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 1000;
    localparam int ITEM_TARGET = 400;

    typedef struct {
        event_t      ev;
        logic        body;
        logic [7:0]  body_byte;
        logic        last;
        logic [31:0] id;
        logic [3:0]  slot;
    } deframe_result_t;

    class deframe_scoreboard;
        logic              backchannel;
        logic [2:0]        mark_count;
        logic [31:0]       mark_word;
        logic [30:0]       body_left;
        logic              final_frag;
        logic [3:0]        rec_count;
        logic [31:0]       rec_id;
        logic [31:0]       rec_dir;
        logic              slot_busy [SLOTS];
        logic [31:0]       slot_id [SLOTS];
        logic              broken;
        deframe_result_t   expected_events [$];
        int                errors;

        function new();
            backchannel = 1'b0;
            mark_count = '0;
            mark_word = '0;
            body_left = '0;
            final_frag = 1'b0;
            rec_count = '0;
            rec_id = '0;
            rec_dir = '0;
            broken = 1'b0;
            errors = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_busy[i] = 1'b0;
                slot_id[i] = '0;
            end
        endfunction

        function int find_slot(logic [31:0] id);
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_busy[i] && slot_id[i] == id)
                    return i;
            end
            return -1;
        endfunction

        function void note_beat(logic [1:0] k, logic [7:0] b, logic [31:0] r);
            deframe_result_t e;
            int hit;
            e.ev = EV_CONSUMED;
            e.body = 1'b0;
            e.body_byte = '0;
            e.last = 1'b0;
            e.id = '0;
            e.slot = '0;
            if (broken)
            begin
                e.ev = EV_REFUSED;
            end
            else if (k == KIND_BYTE)
            begin
                if (body_left == 0)
                begin
                    mark_word = {mark_word[23:0], b};
                    mark_count++;
                    if (mark_count == 3'd4)
                    begin
                        body_left = mark_word[30:0];
                        final_frag = mark_word[31];
                        mark_count = '0;
                        mark_word = '0;
                    end
                end
                else
                begin
                    e.body = 1'b1;
                    e.body_byte = b;
                    body_left--;
                    if (rec_count < 4)
                        rec_id = {rec_id[23:0], b};
                    else if (rec_count < 8)
                        rec_dir = {rec_dir[23:0], b};
                    if (rec_count < 8)
                        rec_count++;
                    if (body_left == 0 && final_frag)
                    begin
                        e.last = 1'b1;
                        if (rec_count < 8)
                        begin
                            e.ev = EV_CORRUPT;
                            broken = 1'b1;
                            for (int i = 0; i < SLOTS; i++)
                                slot_busy[i] = 1'b0;
                        end
                        else
                        begin
                            e.id = rec_id;
                            if (rec_dir == 0)
                            begin
                                e.ev = backchannel ? EV_CALL_ON : EV_CALL_DROP;
                            end
                            else
                            begin
                                hit = find_slot(rec_id);
                                if (hit >= 0)
                                begin
                                    slot_busy[hit] = 1'b0;
                                    e.ev = EV_MATCHED;
                                    e.slot = hit[3:0];
                                end
                                else
                                begin
                                    e.ev = EV_UNMATCHED;
                                end
                            end
                        end
                        rec_count = '0;
                        rec_id = '0;
                        rec_dir = '0;
                    end
                end
            end
            else if (k == KIND_REGISTER)
            begin
                e.ev = EV_FULL;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!slot_busy[i])
                    begin
                        slot_busy[i] = 1'b1;
                        slot_id[i] = r;
                        e.ev = EV_REGISTERED;
                        e.slot = i[3:0];
                        break;
                    end
                end
            end
            else if (k == KIND_WITHDRAW)
            begin
                hit = find_slot(r);
                if (hit >= 0)
                begin
                    slot_busy[hit] = 1'b0;
                    e.ev = EV_WITHDRAWN;
                    e.slot = hit[3:0];
                end
                else
                begin
                    e.ev = EV_NOT_FOUND;
                end
            end
            expected_events.push_back(e);
        endfunction

        function void check_beat(logic [3:0] ev, logic bv, logic [7:0] ob, logic last,
                                 logic [31:0] id, logic [3:0] sl);
            deframe_result_t e;
            if (expected_events.size() == 0)
            begin
                $error("result beat with nothing expected: event_res %0d", ev);
                errors++;
                return;
            end
            e = expected_events.pop_front();
            if (ev !== e.ev)
            begin
                $error("event_res expected %0d got %0d", e.ev, ev);
                errors++;
            end
            if (bv !== e.body)
            begin
                $error("byte_valid expected %0d got %0d", e.body, bv);
                errors++;
            end
            if (ob !== e.body_byte)
            begin
                $error("out_byte expected %02h got %02h", e.body_byte, ob);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("record_last expected %0d got %0d", e.last, last);
                errors++;
            end
            if (id !== e.id)
            begin
                $error("reply_id expected %08h got %08h", e.id, id);
                errors++;
            end
            if (sl !== e.slot)
            begin
                $error("slot expected %0d got %0d", e.slot, sl);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] request_id;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  event_res;
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        record_last;
    logic [31:0] reply_id;
    logic [3:0]  slot;

    deframe_scoreboard sb;
    logic [31:0] issued_ids [$];
    int          items_sent;
    bit          calm;
    int          stall_left;
    int          idle_cycles;

    rpc_record_mark_reply_matcher_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .data_byte  (data_byte),
        .request_id (request_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_res  (event_res),
        .byte_valid (byte_valid),
        .out_byte   (out_byte),
        .record_last(record_last),
        .reply_id   (reply_id),
        .slot       (slot)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // check result beats and vary the stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_beat(event_res, byte_valid, out_byte, record_last, reply_id, slot);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_item(logic [1:0] k, logic [7:0] b, logic [31:0] r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        data_byte <= b;
        request_id <= r;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_beat(k, b, r);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_backchannel(logic v);
        drain();
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.backchannel = v;
        @(posedge clk);
    endtask

    task automatic send_mark(logic [30:0] len, logic fin);
        logic [31:0] w;
        w = {fin, len};
        for (int i = 3; i >= 0; i--)
            send_item(KIND_BYTE, w[8*i +: 8], $urandom);
    endtask

    function automatic logic [31:0] pick_id();
        if (issued_ids.size() > 0 && $urandom_range(0, 3) != 0)
            return issued_ids[$urandom_range(0, issued_ids.size() - 1)];
        return $urandom;
    endfunction

    task automatic register_random();
        logic [31:0] id;
        case ($urandom_range(0, 9))
            0: id = 32'h0;
            1: id = 32'hffff_ffff;
            2: id = pick_id();
            default: id = $urandom;
        endcase
        send_item(KIND_REGISTER, 8'($urandom_range(0, 255)), id);
        issued_ids.push_back(id);
        if (issued_ids.size() > 40)
            void'(issued_ids.pop_front());
    endtask

    task automatic side_item();
        case ($urandom_range(0, 2))
            0: register_random();
            1: send_item(KIND_WITHDRAW, 8'($urandom_range(0, 255)), pick_id());
            default: send_item(KIND_UNUSED, 8'($urandom_range(0, 255)), $urandom);
        endcase
    endtask

    task automatic send_record(logic [31:0] id, logic [31:0] dir, int extra);
        logic [7:0] body [$];
        int left;
        int len;
        int pos;
        for (int i = 3; i >= 0; i--)
            body.push_back(id[8*i +: 8]);
        for (int i = 3; i >= 0; i--)
            body.push_back(dir[8*i +: 8]);
        repeat (extra) body.push_back(8'($urandom_range(0, 255)));
        left = body.size();
        pos = 0;
        while (left > 0)
        begin
            if ($urandom_range(0, 7) == 0)
                send_mark(31'd0, 1'($urandom_range(0, 1)));
            len = ($urandom_range(0, 2) == 0) ? left : $urandom_range(1, left);
            send_mark(31'(len), len == left);
            repeat (len)
            begin
                if ($urandom_range(0, 11) == 0)
                    side_item();
                send_item(KIND_BYTE, body[pos], $urandom);
                pos++;
            end
            left -= len;
        end
    endtask

    task automatic random_record();
        logic [31:0] dir;
        int extra;
        case ($urandom_range(0, 9))
            0, 1, 2: dir = 32'h0;
            3: dir = 32'h1 << $urandom_range(0, 31);
            default: dir = $urandom;
        endcase
        extra = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
        send_record(pick_id(), dir, extra);
    endtask

    task automatic random_step(int reg_w);
        int r;
        r = $urandom_range(0, 99);
        if (r < reg_w)
            register_random();
        else if (r < reg_w + 12)
            send_item(KIND_WITHDRAW, 8'($urandom_range(0, 255)), pick_id());
        else if (r < reg_w + 16)
            send_item(KIND_UNUSED, 8'($urandom_range(0, 255)), $urandom);
        else
            random_record();
    endtask

    initial
    begin
        int phase;
        sb = new();
        items_sent = 0;
        calm = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = 1'b0;
        in_valid = 1'b0;
        kind = KIND_BYTE;
        data_byte = '0;
        request_id = '0;
        out_stall = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_backchannel(1'b0);

        send_item(KIND_UNUSED, 8'hff, 32'hffff_ffff);
        send_item(KIND_WITHDRAW, 8'h00, 32'hffff_ffff);
        send_item(KIND_REGISTER, 8'h00, 32'hffff_ffff);
        send_item(KIND_REGISTER, 8'hff, 32'h0);
        send_mark(31'd0, 1'b1);
        send_mark(31'd8, 1'b1);
        repeat (8) send_item(KIND_BYTE, 8'hff, 32'h0);
        send_item(KIND_WITHDRAW, 8'h00, 32'h0);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            calm = ($urandom_range(0, 3) == 0);
            if (phase == 1)
                repeat (SLOTS + 1) register_random();
            repeat (12) random_step($urandom_range(5, 40));
            set_backchannel(!sb.backchannel);
            phase++;
        end

        // break the link with a short final record
        calm = 1'b0;
        send_mark(31'd5, 1'b1);
        repeat (5) send_item(KIND_BYTE, 8'($urandom_range(0, 255)), $urandom);
        send_item(KIND_BYTE, 8'($urandom_range(0, 255)), $urandom);
        send_item(KIND_REGISTER, 8'($urandom_range(0, 255)), $urandom);
        send_item(KIND_WITHDRAW, 8'($urandom_range(0, 255)), $urandom);
        send_item(KIND_UNUSED, 8'($urandom_range(0, 255)), $urandom);
        drain();
        repeat (40) @(posedge clk);

        if (sb.expected_events.size() != 0)
        begin
            $error("%0d expected result beats never arrived", sb.expected_events.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: rpc_record_mark_reply_matcher_unit.f
rtl/core/rpcrm_pkg.sv
rtl/core/rpc_record_mark_reply_matcher_unit.sv
verif/tb.sv
